// ===== hw/rtl/hvd_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the haversine block.
`timescale 1ns / 1ps

package hvd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SC_LAT       = CORDIC_STEPS + 3;  // fold, scale, rotations, round
  localparam int ISQ_STEPS    = 31;                // one result bit per stage for Q60 input

  typedef logic signed [30:0] lat_t;
  typedef logic signed [31:0] lon_t;
  typedef logic        [30:0] dist_t;
  typedef logic signed [31:0] angle_t;   // 2^-24 degree
  typedef logic signed [31:0] q30_t;
  typedef logic signed [63:0] q60_t;

  localparam logic [63:0]        Q60_ONE  = 64'd1 << 60;
  localparam q60_t               Q29_HALF = 64'sd536870912;
  localparam logic signed [33:0] DEG90    = 34'sd1509949440;
  localparam logic signed [33:0] DEG180   = 34'sd3019898880;

  // distance = round(t30 * 7963761 / (625 * 2^14))
  localparam logic [63:0] DIST_NUM   = 64'd7963761;
  localparam logic [63:0] DIST_RND   = 64'd5120000;
  localparam int          DIST_SHIFT = 14;
  // x / 625 = (x * ceil(2^50 / 625)) >> 50, exact for x < 2^40
  localparam logic [40:0] DIST_RECIP = 41'd1801439850949;
  localparam int          RECIP_SHIFT = 50;

  // Restoring division, elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], num[k]};
      if (r >= den) begin
        r = r - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q60 by truncated power series.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] k;
    p   = udiv64(Q60_ONE, n);
    sum = '0;
    k   = '0;
    while (p != 64'd0) begin
      t = udiv64(p, (k << 1) + 64'd1);
      if (k[0]) sum = sum - t;
      else      sum = sum + t;
      p = udiv64(udiv64(p, n), n);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic q60_t atan_q60(input int i);
    logic [63:0] v;
    if (i == 0) v = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    else        v = atan_recip(64'd1 << i);
    return $signed(v);
  endfunction

  function automatic q60_t cordic_gain();
    q60_t x;
    q60_t y;
    q60_t z;
    q60_t xs;
    q60_t ys;
    x = $signed(Q60_ONE);
    y = '0;
    z = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q60(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q60(i);
      end
    end
    return x;
  endfunction

  function automatic logic [63:0] inv_gain_calc();
    logic [63:0] g;
    logic [63:0] r;
    logic [63:0] q;
    g = cordic_gain();
    r = Q60_ONE;
    q = '0;
    for (int i = 0; i < 60; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= g) begin
        r = r - g;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam q60_t        INV_GAIN     = $signed(inv_gain_calc());
  localparam logic [63:0] PI_Q60       = 64'd4 * (64'd4 * atan_recip(64'd5) -
                                                  atan_recip(64'd239));
  localparam logic [63:0] DEG_TO_RAD64 = (PI_Q60 + 64'd1509949440) / 64'd3019898880;
  localparam q30_t        DEG_TO_RAD   = $signed(DEG_TO_RAD64[31:0]);

  localparam logic [63:0] CAP_T30 = ((PI_Q60 >> 1) + 64'd536870912) >> 30;
  localparam logic [63:0] CAP64   = (CAP_T30 * 64'd127420176 + 64'd81920000) / 64'd163840000;
  localparam dist_t       DIST_CAP = CAP64[30:0];

endpackage

// ===== hw/rtl/hvd_if.sv =====
// Valid/ready channel interfaces for point pairs and distances.
`timescale 1ns / 1ps

interface hvd_in_if;
  logic          valid;
  logic          ready;
  hvd_pkg::lat_t lat_first;
  hvd_pkg::lon_t lon_first;
  hvd_pkg::lat_t lat_second;
  hvd_pkg::lon_t lon_second;

  modport source (output valid, output lat_first, output lon_first,
                  output lat_second, output lon_second, input ready);
  modport sink   (input valid, input lat_first, input lon_first,
                  input lat_second, input lon_second, output ready);
endinterface

interface hvd_out_if;
  logic           valid;
  logic           ready;
  hvd_pkg::dist_t distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

// ===== hw/rtl/hvd_sincos.sv =====
// Pipelined sine/cosine: quadrant fold, radian scaling and rotation-mode CORDIC.
`timescale 1ns / 1ps

module hvd_sincos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  hvd_pkg::angle_t angle,
  output logic          out_vld,
  output hvd_pkg::q30_t sin_o,
  output hvd_pkg::q30_t cos_o
);

  localparam int L = hvd_pkg::CORDIC_STEPS;

  // fold to [-90,90] degrees
  logic signed [33:0] a_ext;
  logic signed [33:0] fold_nxt;
  logic               negc_nxt;
  logic signed [31:0] fold_r;
  logic               negc_f_r;
  logic               vld_f_r;

  hvd_pkg::q60_t z_m_r;
  logic          negc_m_r;
  logic          vld_m_r;

  hvd_pkg::q60_t x_r [L];
  hvd_pkg::q60_t y_r [L];
  hvd_pkg::q60_t z_r [L];
  logic          nc_r [L];
  logic          v_r  [L];

  hvd_pkg::q60_t xr;
  hvd_pkg::q60_t yr;

  always_comb begin
    a_ext    = 34'(angle);
    fold_nxt = a_ext;
    negc_nxt = 1'b0;
    if (a_ext > hvd_pkg::DEG90) begin
      fold_nxt = hvd_pkg::DEG180 - a_ext;
      negc_nxt = 1'b1;
    end else if (a_ext < -hvd_pkg::DEG90) begin
      fold_nxt = -hvd_pkg::DEG180 - a_ext;
      negc_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
      vld_m_r <= 1'b0;
    end else if (en) begin
      vld_f_r <= in_vld;
      vld_m_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_r   <= fold_nxt[31:0];
      negc_f_r <= negc_nxt;
      z_m_r    <= hvd_pkg::q60_t'(fold_r) * hvd_pkg::q60_t'(hvd_pkg::DEG_TO_RAD);
      negc_m_r <= negc_f_r;
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_rot
    localparam hvd_pkg::q60_t ATAN_I = hvd_pkg::atan_q60(i);
    hvd_pkg::q60_t x_in;
    hvd_pkg::q60_t y_in;
    hvd_pkg::q60_t z_in;
    logic          nc_in;
    logic          v_in;

    if (i == 0) begin : g_first
      assign x_in  = hvd_pkg::INV_GAIN;
      assign y_in  = '0;
      assign z_in  = z_m_r;
      assign nc_in = negc_m_r;
      assign v_in  = vld_m_r;
    end else begin : g_next
      assign x_in  = x_r[i-1];
      assign y_in  = y_r[i-1];
      assign z_in  = z_r[i-1];
      assign nc_in = nc_r[i-1];
      assign v_in  = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nc_r[i] <= nc_in;
        if (z_in >= 0) begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - ATAN_I;
        end else begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + ATAN_I;
        end
      end
    end
  end

  // round half up to Q30, restore cosine sign
  assign xr = (x_r[L-1] + hvd_pkg::Q29_HALF) >>> 30;
  assign yr = (y_r[L-1] + hvd_pkg::Q29_HALF) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= yr[31:0];
      cos_o <= nc_r[L-1] ? -xr[31:0] : xr[31:0];
    end
  end

endmodule

// ===== hw/rtl/hvd_isqrt.sv =====
// Pipelined integer square root (floor) of a Q60 value, one result bit per stage.
`timescale 1ns / 1ps

module hvd_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [60:0] val,
  output logic        out_vld,
  output logic [30:0] root
);

  localparam int N = hvd_pkg::ISQ_STEPS;

  logic [62:0] v_r [N];
  logic [62:0] r_r [N];
  logic        q_r [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [62:0] B = 63'd1 << (2 * (N - 1 - j));
    logic [62:0] v_in;
    logic [62:0] r_in;
    logic        q_in;
    logic [62:0] trial;

    if (j == 0) begin : g_first
      assign v_in = 63'(val);
      assign r_in = '0;
      assign q_in = in_vld;
    end else begin : g_next
      assign v_in = v_r[j-1];
      assign r_in = r_r[j-1];
      assign q_in = q_r[j-1];
    end

    assign trial = r_in + B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_r[j] <= 1'b0;
      end else if (en) begin
        q_r[j] <= q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          v_r[j] <= v_in - trial;
          r_r[j] <= (r_in >> 1) + B;
        end else begin
          v_r[j] <= v_in;
          r_r[j] <= r_in >> 1;
        end
      end
    end
  end

  assign out_vld = q_r[N-1];
  assign root    = r_r[N-1][30:0];

endmodule

// ===== hw/rtl/haversine_distance.sv =====
// Top level: fully pipelined haversine great-circle distance.
//
//   in_ch  : point pair (lat/lon of two points, 2^-23 degree, signed). A transfer
//            happens on a clock edge with valid and ready both high.
//   out_ch : distance in 2^-16 km on a sphere of radius 6371.0088 km, saturated
//            at half the circumference. One result per accepted pair, in order.
//   Throughput: one pair per clock unless stalled; stages are register slices.
//   Stages: out_ch.valid follows the input transfer through 94 register
//            stages: angle prep (1), four parallel sin/cos CORDICs (27),
//            haversine products and clamp (5), two parallel square roots (31),
//            vectoring CORDIC (24), scale (2), reciprocal divide by 625 (3) and
//            the output register.
//   Stall: the whole pipe advances together while the skid register is empty.
//            A result the receiver does not take parks in the output register;
//            one more parks in the skid register, and only then does in_ch.ready
//            drop. ready is a register output, so no path runs from out_ch.ready
//            to in_ch.ready. Nothing is lost or duplicated across stalls.
//   Reset: rst_n is synchronous, active low; it clears all valid bits and the
//            skid/output state. Data registers are not reset. No warm-up needed.
`timescale 1ns / 1ps

module haversine_distance (
  input  logic      clk,
  input  logic      rst_n,
  hvd_in_if.sink    in_ch,
  hvd_out_if.source out_ch
);

  localparam int L  = hvd_pkg::CORDIC_STEPS;
  localparam logic signed [66:0] H_MAX = 67'sd1 <<< 60;
  localparam logic [19:0] RC_LO = hvd_pkg::DIST_RECIP[19:0];
  localparam logic [20:0] RC_HI = hvd_pkg::DIST_RECIP[40:20];

  // ---------------------------------------------------------------------------
  // Pipeline advance: all stages move while the skid slot is free
  // ---------------------------------------------------------------------------
  logic adv;
  logic skid_vld_r;
  assign adv         = !skid_vld_r;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: angles in 2^-24 degree. Latitude difference and longitude
  // difference are half angles as given; 2*lat gives full latitude.
  // Longitude difference wraps into [-180,180) degrees with one correction.
  // ---------------------------------------------------------------------------
  logic signed [32:0] dlon;
  logic signed [33:0] wlon;
  hvd_pkg::angle_t    a_dl_r;
  hvd_pkg::angle_t    a_c1_r;
  hvd_pkg::angle_t    a_c2_r;
  hvd_pkg::angle_t    a_w_r;
  logic               vld0_r;

  always_comb begin
    dlon = 33'(in_ch.lon_second) - 33'(in_ch.lon_first);
    if (dlon >= hvd_pkg::DEG90)       wlon = 34'(dlon) - hvd_pkg::DEG180;
    else if (dlon < -hvd_pkg::DEG90)  wlon = 34'(dlon) + hvd_pkg::DEG180;
    else                              wlon = 34'(dlon);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dl_r <= hvd_pkg::angle_t'(in_ch.lat_second) - hvd_pkg::angle_t'(in_ch.lat_first);
      a_c1_r <= $signed({in_ch.lat_first, 1'b0});
      a_c2_r <= $signed({in_ch.lat_second, 1'b0});
      a_w_r  <= wlon[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Four sin/cos units in lock step
  // ---------------------------------------------------------------------------
  hvd_pkg::q30_t s_dl;
  hvd_pkg::q30_t s_w;
  hvd_pkg::q30_t c_1;
  hvd_pkg::q30_t c_2;
  hvd_pkg::q30_t unused_c_dl;
  hvd_pkg::q30_t unused_c_w;
  hvd_pkg::q30_t unused_s_1;
  hvd_pkg::q30_t unused_s_2;
  logic          sc_vld;

  hvd_sincos u_sc_dl (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (vld0_r), .angle (a_dl_r),
    .out_vld (sc_vld), .sin_o (s_dl), .cos_o (unused_c_dl)
  );
  hvd_sincos u_sc_c1 (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (vld0_r), .angle (a_c1_r),
    .out_vld (), .sin_o (unused_s_1), .cos_o (c_1)
  );
  hvd_sincos u_sc_c2 (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (vld0_r), .angle (a_c2_r),
    .out_vld (), .sin_o (unused_s_2), .cos_o (c_2)
  );
  hvd_sincos u_sc_w (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (vld0_r), .angle (a_w_r),
    .out_vld (), .sin_o (s_w), .cos_o (unused_c_w)
  );

  // ---------------------------------------------------------------------------
  // Haversine term h = s_dl^2 + rnd(c1*c2) * rnd(s_w^2), clamped to [0, 1]
  //   H1 products, H2 rounding to Q30, H3 product, H4 sum, H5 clamp
  // ---------------------------------------------------------------------------
  hvd_pkg::q60_t      sq1_r;
  hvd_pkg::q60_t      cc_r;
  hvd_pkg::q60_t      sq2_r;
  logic               h1_vld_r;
  hvd_pkg::q60_t      pr_full;
  hvd_pkg::q60_t      qr_full;
  logic signed [32:0] pr_r;
  logic signed [32:0] qr_r;
  hvd_pkg::q60_t      sq1_d_r;
  logic               h2_vld_r;
  logic signed [65:0] pq_r;
  hvd_pkg::q60_t      sq1_e_r;
  logic               h3_vld_r;
  logic signed [66:0] hs_r;
  logic               h4_vld_r;
  logic [60:0]        h_nxt;
  logic [60:0]        h_r;
  logic [60:0]        hc_r;
  logic               h5_vld_r;

  assign pr_full = (cc_r  + hvd_pkg::Q29_HALF) >>> 30;
  assign qr_full = (sq2_r + hvd_pkg::Q29_HALF) >>> 30;

  always_comb begin
    if (hs_r < 0)          h_nxt = '0;
    else if (hs_r > H_MAX) h_nxt = 61'(hvd_pkg::Q60_ONE);
    else                   h_nxt = hs_r[60:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r <= 1'b0;
      h2_vld_r <= 1'b0;
      h3_vld_r <= 1'b0;
      h4_vld_r <= 1'b0;
      h5_vld_r <= 1'b0;
    end else if (adv) begin
      h1_vld_r <= sc_vld;
      h2_vld_r <= h1_vld_r;
      h3_vld_r <= h2_vld_r;
      h4_vld_r <= h3_vld_r;
      h5_vld_r <= h4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1_r   <= hvd_pkg::q60_t'(s_dl) * hvd_pkg::q60_t'(s_dl);
      cc_r    <= hvd_pkg::q60_t'(c_1)  * hvd_pkg::q60_t'(c_2);
      sq2_r   <= hvd_pkg::q60_t'(s_w)  * hvd_pkg::q60_t'(s_w);
      pr_r    <= pr_full[32:0];
      qr_r    <= qr_full[32:0];
      sq1_d_r <= sq1_r;
      pq_r    <= 66'(pr_r) * 66'(qr_r);
      sq1_e_r <= sq1_d_r;
      hs_r    <= 67'(sq1_e_r) + 67'(pq_r);
      h_r     <= h_nxt;
      hc_r    <= 61'(hvd_pkg::Q60_ONE) - h_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // sqrt(h) and sqrt(1-h), Q30
  // ---------------------------------------------------------------------------
  logic [30:0] ys;
  logic [30:0] xs;
  logic        isq_vld;

  hvd_isqrt u_isq_y (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (h5_vld_r), .val (h_r),
    .out_vld (isq_vld), .root (ys)
  );
  hvd_isqrt u_isq_x (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (h5_vld_r), .val (hc_r),
    .out_vld (), .root (xs)
  );

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: theta = atan2(ys, xs), Q60 radians
  // ---------------------------------------------------------------------------
  hvd_pkg::q60_t vx_r [L];
  hvd_pkg::q60_t vy_r [L];
  hvd_pkg::q60_t vz_r [L];
  logic          vv_r [L];

  for (genvar i = 0; i < L; i++) begin : g_vec
    localparam hvd_pkg::q60_t ATAN_I = hvd_pkg::atan_q60(i);
    hvd_pkg::q60_t x_in;
    hvd_pkg::q60_t y_in;
    hvd_pkg::q60_t z_in;
    logic          v_in;

    if (i == 0) begin : g_first
      assign x_in = hvd_pkg::q60_t'({xs, 30'd0});
      assign y_in = hvd_pkg::q60_t'({ys, 30'd0});
      assign z_in = '0;
      assign v_in = isq_vld;
    end else begin : g_next
      assign x_in = vx_r[i-1];
      assign y_in = vy_r[i-1];
      assign z_in = vz_r[i-1];
      assign v_in = vv_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[i] <= 1'b0;
      end else if (adv) begin
        vv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_in >= 0) begin
          vx_r[i] <= x_in + (y_in >>> i);
          vy_r[i] <= y_in - (x_in >>> i);
          vz_r[i] <= z_in + ATAN_I;
        end else begin
          vx_r[i] <= x_in - (y_in >>> i);
          vy_r[i] <= y_in + (x_in >>> i);
          vz_r[i] <= z_in - ATAN_I;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scale theta to distance: t30 = rnd(theta) (negative counts as zero),
  // n = t30 * 7963761 + 5120000, distance = (n >> 14) / 625
  // theta stays below 1.75 rad, so n >> 14 fits in 40 bits.
  // ---------------------------------------------------------------------------
  hvd_pkg::q60_t theta;
  hvd_pkg::q60_t th_rnd;
  logic [31:0]   t30_r;
  logic          t1_vld_r;
  logic [53:0]   n_r;
  logic          t2_vld_r;

  assign theta  = vz_r[L-1];
  assign th_rnd = (theta + hvd_pkg::Q29_HALF) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r <= vv_r[L-1];
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t30_r <= (theta < 0) ? 32'd0 : th_rnd[31:0];
      n_r   <= 54'(t30_r) * 54'(hvd_pkg::DIST_NUM) + 54'(hvd_pkg::DIST_RND);
    end
  end

  // Division by 625 as a product with the reciprocal, bits [80:50] of x * M.
  //   Q1 four partial products of x's 20-bit halves and M's 20/21-bit parts,
  //   Q2 x_lo*M and x_hi*M, Q3 final sum and quotient.
  logic [39:0]    dx;
  logic [39:0]    pp_ll_r;
  logic [40:0]    pp_lh_r;
  logic [39:0]    pp_hl_r;
  logic [40:0]    pp_hh_r;
  logic           q1_vld_r;
  logic [60:0]    row_l_r;
  logic [60:0]    row_h_r;
  logic           q2_vld_r;
  logic [80:0]    prod;
  hvd_pkg::dist_t quo_r;
  logic           q3_vld_r;

  assign dx   = n_r[53:hvd_pkg::DIST_SHIFT];
  assign prod = 81'(row_l_r) + {row_h_r, 20'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
      q2_vld_r <= 1'b0;
      q3_vld_r <= 1'b0;
    end else if (adv) begin
      q1_vld_r <= t2_vld_r;
      q2_vld_r <= q1_vld_r;
      q3_vld_r <= q2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_ll_r <= 40'(dx[19:0])  * 40'(RC_LO);
      pp_lh_r <= 41'(dx[19:0])  * 41'(RC_HI);
      pp_hl_r <= 40'(dx[39:20]) * 40'(RC_LO);
      pp_hh_r <= 41'(dx[39:20]) * 41'(RC_HI);
      row_l_r <= 61'(pp_ll_r) + {pp_lh_r, 20'd0};
      row_h_r <= 61'(pp_hl_r) + {pp_hh_r, 20'd0};
      quo_r   <= prod[80:hvd_pkg::RECIP_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // Saturation at half circumference, output register and skid slot
  // ---------------------------------------------------------------------------
  hvd_pkg::dist_t d_fin;
  logic           v_last;
  logic           out_vld_r;
  hvd_pkg::dist_t out_r;
  hvd_pkg::dist_t skid_r;
  logic           out_take;

  assign d_fin    = (quo_r > hvd_pkg::DIST_CAP) ? hvd_pkg::DIST_CAP : quo_r;
  assign v_last   = q3_vld_r;
  assign out_take = out_vld_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) skid_vld_r <= 1'b0;
    end else if (v_last) begin
      if (!out_vld_r || out_ch.ready) out_vld_r  <= 1'b1;
      else                            skid_vld_r <= 1'b1;
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) out_r <= skid_r;
    end else if (v_last) begin
      if (!out_vld_r || out_ch.ready) out_r  <= d_fin;
      else                            skid_r <= d_fin;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.distance = out_r;

endmodule
